// File: sv/jac3_pkg.sv
// Shared types, constants and fixed-point helpers for the seven-point Jacobi sweep.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jac3_pkg;

   localparam int DEF_MAX_GRID  = 64;
   localparam int DEF_FRAC_BITS = 40;

   localparam logic [62:0] RST_INV_H2    = 63'd4518602996613120;
   localparam logic [62:0] RST_GRID_STEP = 63'd34902868016;
   localparam logic [62:0] RST_FACTOR    = 63'd10995116;
   localparam logic [62:0] RST_A_COEFF   = 63'd109951162777600000;
   localparam logic [62:0] RST_EPS       = 63'd10995;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [2:0] {
      REG_GRID_SIZE = 3'd0,
      REG_INV_H2    = 3'd1,
      REG_GRID_STEP = 3'd2,
      REG_FACTOR    = 3'd3,
      REG_A_COEFF   = 3'd4,
      REG_EPS       = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      RD_CENTRE = 3'd0,
      RD_IM     = 3'd1,
      RD_IP     = 3'd2,
      RD_JM     = 3'd3,
      RD_JP     = 3'd4,
      RD_KM     = 3'd5,
      RD_KP     = 3'd6
   } rd_sel_type;

   typedef enum logic [3:0] {
      J_X  = 4'd0,
      J_Y  = 4'd1,
      J_Z  = 4'd2,
      J_XX = 4'd3,
      J_YY = 4'd4,
      J_ZZ = 4'd5,
      J_AR = 4'd6,
      J_SH = 4'd7,
      J_UF = 4'd8
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_OLD,
      ST_SUM,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_CHG,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       old_load;
      logic       boundary_pass;
      logic       sum_first;
      logic       sum_add;
      logic       mul_start;
      logic       mul_commit;
      job_type    job;
      logic       chg_update;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic boundary;
      logic mul_done;
      logic out_busy;
   } stat_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add = s[64] ? S64_MIN : S64_MAX;
      end else begin
         sat_add = s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         sat_sub = s[64] ? S64_MIN : S64_MAX;
      end else begin
         sat_sub = s[63:0];
      end
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      mag64 = a[63] ? (64'd0 - 64'(a)) : 64'(a);
   endfunction

endpackage

`default_nettype wire

// File: sv/jac3_mul.sv
// Iterative signed 64x64 fixed-point multiplier: four 32x32 partial products,
// then rounding and saturation. Depends on jac3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jac3_mul #(
   parameter int FRAC_BITS = jac3_pkg::DEF_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               frac_en,
   input  wire logic signed [63:0] op_a,
   input  wire logic signed [63:0] op_b,
   output logic                    done,
   output logic signed [63:0]      prod
);
   import jac3_pkg::*;

   localparam logic [127:0] HALF = 128'(1) << (FRAC_BITS - 1);

   logic [63:0]  ma_ff, mb_ff;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in, done_ff, done_in, neg_ff, frac_ff;
   logic signed [63:0] prod_ff, prod_in;

   logic [31:0]  a32, b32;
   logic [63:0]  pp;
   logic [127:0] pp_sh, rnd;
   logic [63:0]  mag;
   logic         hi_nz, big;

   always_comb begin
      a32 = step_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
      b32 = step_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
      pp  = 64'(a32) * 64'(b32);
      unique case (step_ff[1:0])
         2'd0:    pp_sh = 128'(pp);
         2'd3:    pp_sh = 128'(pp) << 64;
         default: pp_sh = 128'(pp) << 32;
      endcase
      rnd   = frac_ff ? (acc_ff + HALF) : acc_ff;
      mag   = frac_ff ? rnd[FRAC_BITS +: 64] : rnd[63:0];
      hi_nz = frac_ff ? (|rnd[127:FRAC_BITS + 64]) : (|rnd[127:64]);
      big   = hi_nz | mag[63];
      if (neg_ff) begin
         prod_in = big ? S64_MIN : $signed(64'd0 - mag);
      end else begin
         prod_in = big ? S64_MAX : $signed(mag);
      end
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in  = acc_ff + pp_sh;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      if (start) begin
         ma_ff   <= mag64(op_a);
         mb_ff   <= mag64(op_b);
         neg_ff  <= op_a[63] ^ op_b[63];
         frac_ff <= frac_en;
      end
      if (busy_ff && step_ff[2]) begin
         prod_ff <= prod_in;
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: sv/jac3_ctrl.sv
// Controller state machine of the Jacobi sweep: sequences window reads,
// multiplier jobs and result loads. Depends on jac3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jac3_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire jac3_pkg::stat_type stat,
   output jac3_pkg::cmd_type       cmd
);
   import jac3_pkg::*;

   state_type state_ff, state_in;
   logic [2:0] k_ff, k_in;
   job_type job_ff, job_in;

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      job_in     = job_ff;
      cmd        = '0;
      cmd.rd_sel = RD_CENTRE;
      cmd.job    = job_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.go) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_OLD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OLD: begin
            cmd.old_load = 1'b1;
            if (stat.boundary) begin
               cmd.boundary_pass = 1'b1;
               state_in          = ST_OUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IM;
               k_in       = 3'd0;
               state_in   = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_first = (k_ff == 3'd0);
            cmd.sum_add   = (k_ff != 3'd0);
            if (k_ff == 3'd5) begin
               job_in   = J_X;
               state_in = ST_MUL_GO;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = rd_sel_type'(k_ff + 3'd2);
               k_in       = k_ff + 3'd1;
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (stat.mul_done) begin
               cmd.mul_commit = 1'b1;
               if (job_ff == J_UF) begin
                  state_in = ST_CHG;
               end else begin
                  job_in   = job_type'(job_ff + 4'd1);
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_CHG: begin
            cmd.chg_update = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         job_ff   <= J_X;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         job_ff   <= job_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/jac3_dp.sv
// Datapath of the Jacobi sweep: configuration, window memory, counters,
// arithmetic registers and result register. Depends on jac3_pkg and jac3_mul.
`timescale 1ns / 1ps
`default_nettype none

module jac3_dp #(
   parameter int MAX_GRID  = jac3_pkg::DEF_MAX_GRID,
   parameter int FRAC_BITS = jac3_pkg::DEF_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   input  wire logic [2:0]         csr_index,
   input  wire logic [62:0]        csr_data,
   input  wire logic               req_op,
   input  wire logic [63:0]        req_value,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [127:0]            rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast,
   input  wire jac3_pkg::cmd_type  cmd,
   output jac3_pkg::stat_type      stat
);
   import jac3_pkg::*;

   localparam int WIN_DEPTH = 2 * MAX_GRID * MAX_GRID + 1;
   localparam int ADDR_W    = $clog2(WIN_DEPTH);
   localparam int N_W       = $clog2(MAX_GRID + 1);
   localparam int IDX_W     = $clog2(MAX_GRID);
   localparam int PL_W      = $clog2(MAX_GRID * MAX_GRID + 1);
   localparam int CNT_W     = $clog2(MAX_GRID * MAX_GRID * MAX_GRID + MAX_GRID * MAX_GRID + 1);
   localparam int N_RST     = (MAX_GRID < 64) ? MAX_GRID : 64;
   localparam logic [ADDR_W:0] DEPTH_C = (ADDR_W + 1)'(WIN_DEPTH);
   localparam logic signed [63:0] ONE_FX = 64'(1) << FRAC_BITS;
   localparam logic signed [63:0] SIX_FX = 64'(6) << FRAC_BITS;

   logic [N_W-1:0]  n_ff, n_in;
   logic [62:0]     inv_h2_ff, step_ff, factor_ff, acoef_ff, eps_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] wptr_ff, wptr_in, cptr_ff, cptr_in;
   logic [IDX_W-1:0] ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic [62:0]     max_ff, max_in;
   logic            go_ff, go_in;
   logic            valid_ff, valid_in;

   logic [63:0] mem [WIN_DEPTH];
   logic signed [63:0] rdata_ff;
   logic signed [63:0] old_ff, s_ff, x_ff, y_ff, z_ff, r2_ff, rho_ff, t_ff, res_ff;
   logic [127:0] out_data_ff;
   logic out_bnd_ff, out_last_ff;

   logic [PL_W-1:0]  plane;
   logic [CNT_W-1:0] total;
   logic [IDX_W-1:0] nm1;
   logic boundary, last, in_grid, counted, wr_en;
   logic [6:0] g_raw;
   logic [ADDR_W-1:0] off, rd_addr;
   logic [ADDR_W:0] a_sum, a_dif;
   logic signed [63:0] mul_a, mul_b, prod, diff;
   logic mul_frac, mul_done;
   logic [62:0] chg;

   jac3_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .frac_en (mul_frac),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .prod    (prod)
   );

   always_comb begin
      plane    = PL_W'(n_ff * n_ff);
      total    = CNT_W'(plane * n_ff);
      nm1      = IDX_W'(n_ff - N_W'(1));
      boundary = (ci_ff == '0) || (ci_ff == nm1) || (cj_ff == '0) || (cj_ff == nm1) ||
                 (ck_ff == '0) || (ck_ff == nm1);
      last     = (ci_ff == nm1) && (cj_ff == nm1) && (ck_ff == nm1);
      in_grid  = (count_ff < total);
      counted  = cmd.accept && !(in_grid && req_op);
      wr_en    = cmd.accept && in_grid && !req_op;
      go_in    = counted && (count_ff >= CNT_W'(plane));

      unique case (cmd.rd_sel)
         RD_IM, RD_IP: off = ADDR_W'(1);
         RD_JM, RD_JP: off = ADDR_W'(n_ff);
         RD_KM, RD_KP: off = ADDR_W'(plane);
         default:      off = '0;
      endcase
      a_sum = {1'b0, cptr_ff} + {1'b0, off};
      if (a_sum >= DEPTH_C) begin
         a_sum = a_sum - DEPTH_C;
      end
      a_dif = {1'b0, cptr_ff} - {1'b0, off};
      if (a_dif[ADDR_W]) begin
         a_dif = a_dif + DEPTH_C;
      end
      unique case (cmd.rd_sel)
         RD_IP, RD_JP, RD_KP: rd_addr = a_sum[ADDR_W-1:0];
         default:             rd_addr = a_dif[ADDR_W-1:0];
      endcase

      mul_frac = 1'b1;
      unique case (cmd.job)
         J_X: begin mul_a = 64'(ci_ff); mul_b = 64'(step_ff); mul_frac = 1'b0; end
         J_Y: begin mul_a = 64'(cj_ff); mul_b = 64'(step_ff); mul_frac = 1'b0; end
         J_Z: begin mul_a = 64'(ck_ff); mul_b = 64'(step_ff); mul_frac = 1'b0; end
         J_XX: begin mul_a = x_ff; mul_b = x_ff; end
         J_YY: begin mul_a = y_ff; mul_b = y_ff; end
         J_ZZ: begin mul_a = z_ff; mul_b = z_ff; end
         J_AR: begin mul_a = 64'(acoef_ff); mul_b = r2_ff; end
         J_SH: begin mul_a = s_ff; mul_b = 64'(inv_h2_ff); end
         J_UF: begin mul_a = t_ff; mul_b = 64'(factor_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase

      diff = sat_sub(res_ff, old_ff);
      if (diff[63]) begin
         chg = (diff == S64_MIN) ? 63'(S64_MAX) : 63'(64'd0 - 64'(diff));
      end else begin
         chg = diff[62:0];
      end

      n_in     = n_ff;
      count_in = counted ? (count_ff + CNT_W'(1)) : count_ff;
      wptr_in  = wptr_ff;
      if (wr_en) begin
         wptr_in = (wptr_ff == ADDR_W'(WIN_DEPTH - 1)) ? '0 : (wptr_ff + ADDR_W'(1));
      end
      cptr_in = cptr_ff;
      ci_in   = ci_ff;
      cj_in   = cj_ff;
      ck_in   = ck_ff;
      max_in  = max_ff;
      if (cmd.chg_update && (chg > max_ff)) begin
         max_in = chg;
      end
      valid_in = valid_ff && !rsp_tready;
      if (cmd.out_load) begin
         valid_in = 1'b1;
         if (last) begin
            count_in = '0;
            wptr_in  = '0;
            cptr_in  = '0;
            ci_in    = '0;
            cj_in    = '0;
            ck_in    = '0;
            max_in   = '0;
         end else begin
            cptr_in = (cptr_ff == ADDR_W'(WIN_DEPTH - 1)) ? '0 : (cptr_ff + ADDR_W'(1));
            if (ci_ff == nm1) begin
               ci_in = '0;
               if (cj_ff == nm1) begin
                  cj_in = '0;
                  ck_in = ck_ff + IDX_W'(1);
               end else begin
                  cj_in = cj_ff + IDX_W'(1);
               end
            end else begin
               ci_in = ci_ff + IDX_W'(1);
            end
         end
      end
      g_raw = csr_data[6:0];
      if (csr_valid && (reg_index_type'(csr_index) == REG_GRID_SIZE)) begin
         if (g_raw < 7'd3) begin
            n_in = N_W'(3);
         end else if (32'(g_raw) > MAX_GRID) begin
            n_in = N_W'(MAX_GRID);
         end else begin
            n_in = N_W'(g_raw);
         end
         count_in = '0;
         wptr_in  = '0;
         cptr_in  = '0;
         ci_in    = '0;
         cj_in    = '0;
         ck_in    = '0;
         max_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= N_W'(N_RST);
         inv_h2_ff <= RST_INV_H2;
         step_ff   <= RST_GRID_STEP;
         factor_ff <= RST_FACTOR;
         acoef_ff  <= RST_A_COEFF;
         eps_ff    <= RST_EPS;
         count_ff  <= '0;
         wptr_ff   <= '0;
         cptr_ff   <= '0;
         ci_ff     <= '0;
         cj_ff     <= '0;
         ck_ff     <= '0;
         max_ff    <= '0;
         go_ff     <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         n_ff     <= n_in;
         count_ff <= count_in;
         wptr_ff  <= wptr_in;
         cptr_ff  <= cptr_in;
         ci_ff    <= ci_in;
         cj_ff    <= cj_in;
         ck_ff    <= ck_in;
         max_ff   <= max_in;
         go_ff    <= go_in;
         valid_ff <= valid_in;
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_INV_H2:    inv_h2_ff <= csr_data;
               REG_GRID_STEP: step_ff   <= csr_data;
               REG_FACTOR:    factor_ff <= csr_data;
               REG_A_COEFF:   acoef_ff  <= csr_data;
               REG_EPS:       eps_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wptr_ff] <= req_value;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.old_load) begin
         old_ff <= rdata_ff;
      end
      if (cmd.boundary_pass) begin
         res_ff <= rdata_ff;
      end
      if (cmd.sum_first) begin
         s_ff <= rdata_ff;
      end else if (cmd.sum_add) begin
         s_ff <= sat_add(s_ff, rdata_ff);
      end
      if (cmd.mul_commit) begin
         unique case (cmd.job)
            J_X:  x_ff   <= sat_add(-ONE_FX, prod);
            J_Y:  y_ff   <= sat_add(-ONE_FX, prod);
            J_Z:  z_ff   <= sat_add(-ONE_FX, prod);
            J_XX: r2_ff  <= prod;
            J_YY: r2_ff  <= sat_add(r2_ff, prod);
            J_ZZ: r2_ff  <= sat_add(r2_ff, prod);
            J_AR: rho_ff <= sat_sub(SIX_FX, prod);
            J_SH: t_ff   <= sat_sub(prod, rho_ff);
            J_UF: res_ff <= prod;
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         out_data_ff <= {last && (max_ff <= eps_ff), max_ff, 64'(res_ff)};
         out_bnd_ff  <= boundary;
         out_last_ff <= last;
      end
   end

   always_comb begin
      stat.go       = go_ff;
      stat.boundary = boundary;
      stat.mul_done = mul_done;
      stat.out_busy = valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_bnd_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// File: sv/jacobi_3d_seven_point_sweep.sv
// Top level of the seven-point Jacobi sweep: controller, datapath and checks.
// Depends on jac3_pkg, jac3_ctrl and jac3_dp.
//
//   Channel   Direction  Beat contents
//   req_      in         tuser: operation; tdata: old_value
//   rsp_      out        tuser: is_boundary; tlast: sweep_last;
//                        tdata: new_value, largest_change, converged
//   csr_      in         csr_index: register, csr_data: value
//
// Each interior point runs nine 64x64 products through one shared 32x32
// multiplier, four partial products each. A new item is accepted only when the
// block is idle again. Reset clears the control state, the configuration and
// the sweep counters; the window memory is not cleared.
// A stalled result port holds the block in its final state until the beat leaves.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_3d_seven_point_sweep #(
   parameter int MAX_GRID  = jac3_pkg::DEF_MAX_GRID,
   parameter int FRAC_BITS = jac3_pkg::DEF_FRAC_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // old_value
   input  wire logic         req_tuser,   // operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // new_value, largest_change, converged
   output logic              rsp_tuser,   // is_boundary
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [62:0]  csr_data
);
   import jac3_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   jac3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   jac3_dp #(.MAX_GRID(MAX_GRID), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_op     (req_tuser),
      .req_value  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !stat.out_busy)
      else $error("result loaded over a stalled beat");

   a_mul_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> !stat.mul_done)
      else $error("multiplier finished too early");

   a_conv_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[127] |-> rsp_tlast)
      else $error("converged flag off the last point");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for the seven-point Jacobi sweep: a queue-fed driver, a monitor
// and a predictor of the stencil update, largest change and convergence flag.
// Depends on jac3_pkg and jacobi_3d_seven_point_sweep.
`timescale 1ns / 1ps

module tb_top;
   import jac3_pkg::*;

   localparam logic OP_VALUE = 1'b0;
   localparam logic OP_PAD   = 1'b1;
   localparam int   WATCHDOG = 20000;
   localparam int   SETTLE   = 150;
   localparam int   ITEMS    = 1950;
   localparam logic [62:0] MAX63 = {63{1'b1}};

   typedef struct {
      logic               op;
      logic signed [63:0] val;
   } grid_beat_type;

   typedef struct {
      logic signed [63:0] new_value;
      logic               boundary;
      logic [62:0]        largest;
      logic               last;
      logic               conv;
   } point_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [62:0] csr_data = '0;

   jacobi_3d_seven_point_sweep DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   grid_beat_type    pending_q[$];
   point_result_type expected_q[$];
   grid_beat_type    cur_beat;

   int  n_axis;
   logic [62:0] inv_h2_r, step_r, factor_r, a_r, eps_r;
   logic signed [63:0] sweep_vals[0:262143];
   int  taken, ci, cj, ck;
   logic signed [63:0] run_max;

   int  errors = 0;
   int  beats_in = 0, results_out = 0, boundaries = 0, interiors = 0;
   int  sweeps_done = 0, converged_seen = 0, csr_writes = 0;
   bit  quiet = 1'b0;
   bit  noisy = 1'b1;
   bit  hold_req = 1'b0, hold_done = 1'b0;
   int  hold_cnt = 0, rx_gap = 0, tx_gap = 0, idle_cycles = 0;

   function automatic logic signed [63:0] add_s(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sub_s(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s[63:0];
   endfunction

   function automatic logic [127:0] abs128(logic signed [63:0] a);
      logic [63:0] m;
      m = a[63] ? (64'd0 - a) : a;
      return {64'd0, m};
   endfunction

   function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic [127:0] p;
      p = abs128(a) * abs128(b);
      p = (p + (128'd1 << 39)) >> 40;
      if (a[63] != b[63]) begin
         if (p >= (128'd1 << 63)) return 64'sh8000_0000_0000_0000;
         return -$signed(p[63:0]);
      end
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] axis_pos(int idx);
      logic [127:0] p;
      logic signed [63:0] m;
      p = 128'(idx) * {65'd0, step_r};
      m = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : p[63:0];
      return add_s(-(64'sd1 <<< 40), m);
   endfunction

   task automatic restart_sweep();
      taken = 0; ci = 0; cj = 0; ck = 0; run_max = '0;
   endtask

   task automatic apply_csr(reg_index_type idx, logic [62:0] v);
      case (idx)
         REG_GRID_SIZE: begin
            n_axis = v[6:0] < 3 ? 3 : (v[6:0] > 64 ? 64 : int'(v[6:0]));
            restart_sweep();
         end
         REG_INV_H2:    inv_h2_r = v;
         REG_GRID_STEP: step_r = v;
         REG_FACTOR:    factor_r = v;
         REG_A_COEFF:   a_r = v;
         REG_EPS:       eps_r = v;
         default: ;
      endcase
   endtask

   task automatic predict_point(grid_beat_type b);
      int plane, total, c;
      logic signed [63:0] x, y, z, r2, rho, s, diff, chg;
      point_result_type r;
      plane = n_axis * n_axis;
      total = plane * n_axis;
      if (taken < total) begin
         if (b.op == OP_PAD) return;
         sweep_vals[taken] = b.val;
      end
      taken++;
      if (taken <= plane) return;
      c = taken - 1 - plane;
      r.boundary = (ci == 0 || ci == n_axis - 1 || cj == 0 || cj == n_axis - 1 ||
                    ck == 0 || ck == n_axis - 1);
      if (r.boundary) begin
         r.new_value = sweep_vals[c];
      end else begin
         x = axis_pos(ci); y = axis_pos(cj); z = axis_pos(ck);
         r2 = add_s(add_s(qmul(x, x), qmul(y, y)), qmul(z, z));
         rho = sub_s(64'sd6 <<< 40, qmul({1'b0, a_r}, r2));
         s = add_s(sweep_vals[c - 1], sweep_vals[c + 1]);
         s = add_s(s, sweep_vals[c - n_axis]);
         s = add_s(s, sweep_vals[c + n_axis]);
         s = add_s(s, sweep_vals[c - plane]);
         s = add_s(s, sweep_vals[c + plane]);
         r.new_value = qmul(sub_s(qmul(s, {1'b0, inv_h2_r}), rho), {1'b0, factor_r});
         diff = sub_s(r.new_value, sweep_vals[c]);
         chg = diff[63] ? (diff == 64'sh8000_0000_0000_0000 ? 64'sh7FFF_FFFF_FFFF_FFFF : -diff)
                        : diff;
         if (chg > run_max) run_max = chg;
      end
      r.last = (c == total - 1);
      r.largest = run_max[62:0];
      r.conv = r.last && (run_max <= $signed({1'b0, eps_r}));
      expected_q.push_back(r);
      if (r.last) restart_sweep();
      else if (++ci >= n_axis) begin
         ci = 0;
         if (++cj >= n_axis) begin
            cj = 0;
            ck++;
         end
      end
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want, results_out);
      errors++;
   endtask

   // Driver: presents queued beats, predicts each one when accepted.
   always @(posedge clock) begin
      bit fire, give;
      fire = req_tvalid && req_tready;
      give = req_tvalid && !fire;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (fire) begin
            predict_point(cur_beat);
            beats_in++;
         end
         if (!give) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (!quiet && noisy && $urandom_range(0, 11) == 0) begin
               tx_gap = $urandom_range(0, 3);
            end else if (pending_q.size() > 0) begin
               cur_beat = pending_q.pop_front();
               give = 1'b1;
            end
         end
         req_tvalid <= give;
         req_tdata <= cur_beat.val;
         req_tuser <= cur_beat.op;
      end
   end

   // Receiver back-pressure and result checking.
   always @(posedge clock) begin
      point_result_type w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_out++;
            if (expected_q.size() == 0) begin
               report("unexpected result", rsp_tdata[63:0], '0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_tdata[63:0] !== w.new_value) report("new_value", rsp_tdata[63:0], w.new_value);
               if (rsp_tuser !== w.boundary)
                  report("is_boundary", 64'(rsp_tuser), 64'(w.boundary));
               if (rsp_tdata[126:64] !== w.largest)
                  report("largest_change", 64'(rsp_tdata[126:64]), 64'(w.largest));
               if (rsp_tlast !== w.last) report("sweep_last", 64'(rsp_tlast), 64'(w.last));
               if (rsp_tdata[127] !== w.conv)
                  report("converged", 64'(rsp_tdata[127]), 64'(w.conv));
               if (w.boundary) boundaries++; else interiors++;
               if (w.last) sweeps_done++;
               if (w.conv) converged_seen++;
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt = 400;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && noisy && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("[jacobi_3d_seven_point_sweep] ERROR");
            $finish;
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [62:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(idx, v);
      csr_writes++;
   endtask

   task automatic drain_all();
      while (pending_q.size() > 0 || req_tvalid || expected_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return 64'sh7FFF_FFFF_FFFF_FFFF;
         2: return 64'sh8000_0000_0000_0000;
         default: return $signed({{22{$urandom_range(0, 1) == 1}}, 10'($urandom), $urandom});
      endcase
   endfunction

   function automatic logic [62:0] pick_reg(logic [62:0] dflt);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MAX63;
         2: return 63'({$urandom, $urandom} >> 1);
         3: return 63'($urandom) << $urandom_range(0, 30);
         default: return dflt;
      endcase
   endfunction

   task automatic push(logic op, logic signed [63:0] v);
      grid_beat_type b;
      b.op = op;
      b.val = v;
      pending_q.push_back(b);
   endtask

   // Up to one sweep of n per axis; with junk, stray pads in grid and values in drain.
   task automatic queue_sweep(int n, int upto, bit junk);
      int count;
      count = 0;
      for (int p = 0; p < n * n * n && count < upto; p++) begin
         if (junk && $urandom_range(0, 15) == 0) push(OP_PAD, pick_value());
         push(OP_VALUE, pick_value());
         count++;
      end
      for (int p = 0; p < n * n && count < upto; p++) begin
         push((junk && $urandom_range(0, 3) == 0) ? OP_VALUE : OP_PAD, pick_value());
         count++;
      end
   endtask

   initial begin
      int n, budget, sent;
      n_axis = 64;
      inv_h2_r = RST_INV_H2; step_r = RST_GRID_STEP; factor_r = RST_FACTOR;
      a_r = RST_A_COEFF; eps_r = RST_EPS;
      restart_sweep();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_GRID_SIZE, 63'd0);
      for (int p = 0; p < 27; p++)
         push(OP_VALUE, (p % 3 == 0) ? 64'sh7FFF_FFFF_FFFF_FFFF :
                        (p % 3 == 1) ? 64'sh8000_0000_0000_0000 : 64'(p - 14) <<< 38);
      push(OP_PAD, '0);
      for (int p = 0; p < 9; p++) push(p == 4 ? OP_VALUE : OP_PAD, -64'sd1);
      drain_all();
      csr_write(REG_GRID_SIZE, 63'd4);
      csr_write(REG_INV_H2, MAX63);
      csr_write(REG_GRID_STEP, MAX63);
      csr_write(REG_FACTOR, MAX63);
      csr_write(REG_A_COEFF, MAX63);
      csr_write(REG_EPS, MAX63);
      queue_sweep(4, 1000, 1'b0);
      drain_all();
      csr_write(REG_GRID_SIZE, 63'd127);
      csr_write(REG_EPS, '0);
      for (int p = 0; p < 200; p++) push(OP_VALUE, pick_value());
      drain_all();

      budget = ITEMS - beats_in;
      sent = beats_in;
      while (beats_in - sent < budget) begin
         noisy = $urandom_range(0, 4) != 0;
         if ($urandom_range(0, 2) == 0) begin
            csr_write(REG_INV_H2, pick_reg(RST_INV_H2));
            csr_write(REG_GRID_STEP, pick_reg(RST_GRID_STEP));
            csr_write(REG_FACTOR, pick_reg(RST_FACTOR));
            csr_write(REG_A_COEFF, pick_reg(RST_A_COEFF));
            csr_write(REG_EPS, pick_reg(RST_EPS));
         end
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 6) : $urandom_range(3, 4);
         csr_write(REG_GRID_SIZE, 63'(n));
         if (beats_in - sent > budget / 2 && !hold_done) hold_req = 1'b1;
         if (beats_in - sent > budget * 4 / 5) quiet = 1'b1;
         if ($urandom_range(0, 7) == 0)
            queue_sweep(n, $urandom_range(1, n * n * n + n * n - 1), 1'b1);
         else
            for (int s = $urandom_range(1, 2); s > 0; s--)
               queue_sweep(n, 1000, 1'($urandom_range(0, 1)));
         drain_all();
      end

      $display("covered %0d input beats, %0d results (%0d boundary, %0d interior), %0d sweeps",
               beats_in, results_out, boundaries, interiors, sweeps_done);
      $display("with %0d register writes and %0d converged sweeps", csr_writes, converged_seen);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("[jacobi_3d_seven_point_sweep] OK");
      end else begin
         $display("[jacobi_3d_seven_point_sweep] ERROR");
      end
      $finish;
   end

endmodule
